// ===== sv/q2e_pkg.sv =====
// Shared constants, types and helper functions of the quaternion to Euler angle converter.
`default_nettype none

package q2e_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = DATA_WIDTH - 2;

    // product of two parts brought to Q28
    localparam int Q28_SH  = 2 * FRAC_BITS - 28;
    localparam int Q28_SHR = (Q28_SH > 0) ? Q28_SH : 0;
    localparam int Q28_SHL = (Q28_SH < 0) ? -Q28_SH : 0;
    localparam int PW      = 32;   // Q28 product, magnitude up to 2^30
    localparam int VW      = 34;   // CORDIC input vectors, magnitude up to 2^32
    localparam int CW      = 36;   // CORDIC x/y datapath, covers gain and quarter turn
    localparam int ZW      = 28;   // CORDIC angle, radians * 2^24
    localparam int AW      = 30;   // post-processing angle width
    localparam int SQ_BITS = 29;   // bits of sqrt(2^56 - s^2)
    localparam int RAD_W   = 57;   // radicand width
    localparam int NRM_STEPS = 5;  // normalize shifts of 16, 8, 4, 2, 1
    localparam int ATAN_LEN  = 31;

    localparam int ANG_PI      = 52707179;
    localparam int ANG_HALF_PI = 26353589;
    localparam int OUT_PI      = 25736;
    localparam int OUT_HALF_PI = 12868;
    localparam int ONE_Q28     = 1 << 28;

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
        28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
        28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
        28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32,
        28'sd16, 28'sd8, 28'sd4, 28'sd2, 28'sd1,
        28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0
    };

    localparam logic signed [AW-1:0] ANG_RND = AW'(1024);

    // flags that ride along with every item
    typedef struct packed {
        logic lock;
        logic s_pos;
    } q2e_tag_t;

    // vectors and flags handed from the front end to the angle units
    typedef struct packed {
        logic                 lock;
        logic                 s_pos;
        logic signed [VW-1:0] s;
        logic signed [VW-1:0] ry;
        logic signed [VW-1:0] rx;
        logic signed [VW-1:0] yy;
        logic signed [VW-1:0] yx;
    } q2e_side_t;

    function automatic logic signed [PW-1:0] to_q28(input logic signed [2*DATA_WIDTH-1:0] p);
        logic signed [63:0] e;
        e = 64'(p);
        e = (e <<< Q28_SHL) >>> Q28_SHR;
        return PW'(e);
    endfunction

    // round to Q3.13 and saturate
    function automatic logic signed [AW-1:0] ang_out(input logic signed [AW-1:0] z,
                                                     input logic signed [AW-1:0] lim);
        logic signed [AW-1:0] r;
        r = (z + ANG_RND) >>> 11;
        if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
// Top level: unit quaternion in, roll, pitch and yaw in Q3.13 radians out.
//
//  Channel   Dir  tdata fields (low bit up)                         tuser
//  s_axis    in   q_scalar[15:0] q_first[31:16] q_second[47:32]     -
//                 q_third[63:48]
//  m_axis    out  roll[15:0] pitch[30:16] yaw[46:31] zero[47]       gimbal_lock
//
// One request enters per cycle while m_axis is not stalled; each result passes
// the front end, the 29-stage square root in front of the pitch CORDIC, the
// CORDIC with its 16 rotation stages and the output registers, in that order.
// rst_n clears every valid bit at once; no clearing pass follows.
// A stall on m_axis freezes the whole pipeline in place, so requests are held,
// never dropped or repeated; s_axis_tready falls in the same cycle.
`default_nettype none

module quaternion_to_euler_angles import q2e_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // q_scalar, q_first, q_second, q_third
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // roll, pitch, yaw, zero pad
    output logic             m_axis_tuser    // gimbal_lock
);

    logic adv;

    logic      fe_valid;
    q2e_side_t fe_side;
    logic signed [SQ_BITS-1:0] fe_s_arg;

    logic      sq_valid;
    q2e_side_t sq_side;
    logic [SQ_BITS-1:0] sq_root;

    q2e_tag_t  sq_tag;
    logic      cp_valid;
    q2e_tag_t  cp_tag;
    logic signed [ZW-1:0] zp, zr, zy;

    logic p1_valid_reg;
    q2e_tag_t p1_tag_reg;
    logic signed [AW-1:0] p1_roll_reg, p1_pz_reg, p1_yz_reg;
    logic signed [AW-1:0] roll_next;

    logic out_valid_reg;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [YAW_W-1:0]   yaw_reg;
    logic lock_reg;
    logic signed [AW-1:0] roll_o, pitch_o, yaw_o;

    localparam logic signed [AW-1:0] ANG_PI_A  = AW'(ANG_PI);
    localparam logic signed [AW-1:0] ANG_2PI_A = AW'(2 * ANG_PI);
    localparam logic signed [AW-1:0] LIM_PI    = AW'(OUT_PI);
    localparam logic signed [AW-1:0] LIM_HALF  = AW'(OUT_HALF_PI);

    // advance everything whenever the output register is free or being emptied
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    q2e_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .q0        (s_axis_tdata[15:0]),
        .q1        (s_axis_tdata[31:16]),
        .q2        (s_axis_tdata[47:32]),
        .q3        (s_axis_tdata[63:48]),
        .out_valid (fe_valid),
        .out_side  (fe_side),
        .out_s_arg (fe_s_arg)
    );

    q2e_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fe_valid),
        .in_side   (fe_side),
        .in_s_arg  (fe_s_arg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    assign sq_tag.lock  = sq_side.lock;
    assign sq_tag.s_pos = sq_side.s_pos;

    // pitch unit carries valid and flags; roll and yaw run in lockstep with it
    q2e_cordic u_pitch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_y      (sq_side.s),
        .in_x      ($signed({{(VW-SQ_BITS){1'b0}}, sq_root})),
        .out_valid (cp_valid),
        .out_tag   (cp_tag),
        .out_z     (zp)
    );

    q2e_cordic u_roll
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_y      (sq_side.ry),
        .in_x      (sq_side.rx),
        .out_valid (),
        .out_tag   (),
        .out_z     (zr)
    );

    q2e_cordic u_yaw
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_y      (sq_side.yy),
        .in_x      (sq_side.yx),
        .out_valid (),
        .out_tag   (),
        .out_z     (zy)
    );

    // gimbal lock: roll = -/+ 2*atan2(q1, q0), wrapped into [-pi, pi]
    always_comb
    begin
        roll_next = AW'(zr);
        if (cp_tag.lock)
        begin
            roll_next = AW'(zr) <<< 1;
            if (cp_tag.s_pos)
            begin
                roll_next = -roll_next;
            end
            if (roll_next > ANG_PI_A)
            begin
                roll_next = roll_next - ANG_2PI_A;
            end
            if (roll_next < -ANG_PI_A)
            begin
                roll_next = roll_next + ANG_2PI_A;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= cp_valid;
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_tag_reg  <= cp_tag;
            p1_roll_reg <= roll_next;
            p1_pz_reg   <= AW'(zp);
            p1_yz_reg   <= AW'(zy);
        end
    end

    // round and saturate; lock forces pitch to +-pi/2 and yaw to zero
    always_comb
    begin
        roll_o  = ang_out(p1_roll_reg, LIM_PI);
        pitch_o = ang_out(p1_pz_reg, LIM_HALF);
        yaw_o   = ang_out(p1_yz_reg, LIM_PI);
        if (p1_tag_reg.lock)
        begin
            pitch_o = p1_tag_reg.s_pos ? LIM_HALF : -LIM_HALF;
            yaw_o   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= roll_o[ROLL_W-1:0];
            pitch_reg <= pitch_o[PITCH_W-1:0];
            yaw_reg   <= yaw_o[YAW_W-1:0];
            lock_reg  <= p1_tag_reg.lock;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, yaw_reg, pitch_reg, roll_reg};
    assign m_axis_tuser  = lock_reg;

endmodule

`default_nettype wire

// ===== sv/q2e_front.sv =====
// Front end: part products and the sums that feed the pitch, roll and yaw units.
`default_nettype none

module q2e_front import q2e_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic signed [DATA_WIDTH-1:0]  q0,
    input  wire logic signed [DATA_WIDTH-1:0]  q1,
    input  wire logic signed [DATA_WIDTH-1:0]  q2,
    input  wire logic signed [DATA_WIDTH-1:0]  q3,
    output logic                               out_valid,
    output q2e_side_t                          out_side,
    output logic signed [SQ_BITS-1:0]          out_s_arg
);

    logic v1_reg, v2_reg;
    logic signed [PW-1:0] p01_reg, p02_reg, p03_reg, p12_reg, p13_reg, p23_reg;
    logic signed [PW-1:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [DATA_WIDTH-1:0] q0_reg, q1_reg;
    q2e_side_t side_reg;
    logic signed [SQ_BITS-1:0] sarg_reg;

    logic signed [VW-1:0] s_next, ry_next, rx_next, yy_next, yx_next;
    logic lock_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= to_q28(q0 * q0);
            p11_reg <= to_q28(q1 * q1);
            p22_reg <= to_q28(q2 * q2);
            p33_reg <= to_q28(q3 * q3);
            p01_reg <= to_q28(q0 * q1);
            p02_reg <= to_q28(q0 * q2);
            p03_reg <= to_q28(q0 * q3);
            p12_reg <= to_q28(q1 * q2);
            p13_reg <= to_q28(q1 * q3);
            p23_reg <= to_q28(q2 * q3);
            q0_reg  <= q0;
            q1_reg  <= q1;
        end
    end

    always_comb
    begin
        s_next  = (VW'(p02_reg) + VW'(p13_reg)) <<< 1;
        ry_next = (VW'(p01_reg) + VW'(p23_reg)) <<< 1;
        rx_next = VW'(p00_reg) - VW'(p11_reg) - VW'(p22_reg) + VW'(p33_reg);
        yy_next = (VW'(p03_reg) + VW'(p12_reg)) <<< 1;
        yx_next = VW'(p00_reg) + VW'(p11_reg) - VW'(p22_reg) - VW'(p33_reg);
        lock_next = (s_next >= VW'(ONE_Q28)) || (s_next <= -VW'(ONE_Q28));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg.lock  <= lock_next;
            side_reg.s_pos <= (s_next > VW'(0));
            side_reg.s     <= s_next;
            // at gimbal lock the roll unit resolves atan2(q1, q0)
            side_reg.ry    <= lock_next ? VW'(q1_reg) : ry_next;
            side_reg.rx    <= lock_next ? VW'(q0_reg) : rx_next;
            side_reg.yy    <= yy_next;
            side_reg.yx    <= yx_next;
            sarg_reg       <= lock_next ? '0 : s_next[SQ_BITS-1:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side_reg;
    assign out_s_arg = sarg_reg;

endmodule

`default_nettype wire

// ===== sv/q2e_isqrt.sv =====
// Pipelined exact square root of 2^56 - s^2, one root bit per stage.
`default_nettype none

module q2e_isqrt import q2e_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       adv,
    input  wire logic                       in_valid,
    input  wire q2e_side_t                  in_side,
    input  wire logic signed [SQ_BITS-1:0]  in_s_arg,
    output logic                            out_valid,
    output q2e_side_t                       out_side,
    output logic [SQ_BITS-1:0]              out_root
);

    localparam int TOT = SQ_BITS + 2;
    localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << (RAD_W - 1);

    logic      vl_reg [0:TOT-1];
    q2e_side_t sd_reg [0:TOT-1];
    logic [RAD_W-1:0] sq_reg;
    logic [RAD_W-1:0] rm_reg [0:SQ_BITS];
    logic [RAD_W-1:0] rt_reg [0:SQ_BITS];
    logic signed [2*SQ_BITS-1:0] sq_full;

    assign sq_full = in_s_arg * in_s_arg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TOT; j++)
            begin
                vl_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vl_reg[0] <= in_valid;
            for (int j = 1; j < TOT; j++)
            begin
                vl_reg[j] <= vl_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= in_side;
            for (int j = 1; j < TOT; j++)
            begin
                sd_reg[j] <= sd_reg[j-1];
            end
            sq_reg    <= sq_full[RAD_W-1:0];
            rm_reg[0] <= RAD_ONE - sq_reg;
            rt_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= SQ_BITS; k++)
    begin : g_digit
        localparam int BI = SQ_BITS - k;
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * BI);
        logic [RAD_W:0] trial;

        assign trial = {1'b0, rt_reg[k-1]} + {1'b0, BIT};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if ({1'b0, rm_reg[k-1]} >= trial)
                begin
                    rm_reg[k] <= rm_reg[k-1] - trial[RAD_W-1:0];
                    rt_reg[k] <= (rt_reg[k-1] >> 1) + BIT;
                end
                else
                begin
                    rm_reg[k] <= rm_reg[k-1];
                    rt_reg[k] <= rt_reg[k-1] >> 1;
                end
            end
        end
    end

    assign out_valid = vl_reg[TOT-1];
    assign out_side  = sd_reg[TOT-1];
    assign out_root  = rt_reg[SQ_BITS][SQ_BITS-1:0];

endmodule

`default_nettype wire

// ===== sv/q2e_cordic.sv =====
// Pipelined CORDIC vectoring unit: atan2(y, x) with normalize and quarter-turn stages.
`default_nettype none

module q2e_cordic import q2e_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire q2e_tag_t              in_tag,
    input  wire logic signed [VW-1:0]  in_y,
    input  wire logic signed [VW-1:0]  in_x,
    output logic                       out_valid,
    output q2e_tag_t                   out_tag,
    output logic signed [ZW-1:0]       out_z
);

    localparam int TOT = NRM_STEPS + 2 + CORDIC_STEPS;

    typedef struct packed {
        logic     zero;
        q2e_tag_t tag;
    } meta_t;

    logic  v_reg  [0:TOT-1];
    meta_t mt_reg [0:TOT-1];
    logic signed [CW-1:0] nx_reg [0:NRM_STEPS];
    logic signed [CW-1:0] ny_reg [0:NRM_STEPS];
    logic [VW-1:0]        nm_reg [0:NRM_STEPS];
    logic signed [CW-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STEPS];

    logic [VW-1:0] ax, ay;
    meta_t meta_in;

    assign ax = in_x[VW-1] ? VW'(-in_x) : VW'(in_x);
    assign ay = in_y[VW-1] ? VW'(-in_y) : VW'(in_y);
    assign meta_in.zero = (ax == '0) && (ay == '0);
    assign meta_in.tag  = in_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TOT; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int j = 1; j < TOT; j++)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mt_reg[0] <= meta_in;
            for (int j = 1; j < TOT; j++)
            begin
                mt_reg[j] <= mt_reg[j-1];
            end
            nx_reg[0] <= CW'(in_x);
            ny_reg[0] <= CW'(in_y);
            nm_reg[0] <= ax | ay;
        end
    end

    // scale up until the larger magnitude reaches 2^30
    for (genvar k = 1; k <= NRM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NRM_STEPS - k);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (nm_reg[k-1][VW-1:31-SH] == '0)
                begin
                    nx_reg[k] <= nx_reg[k-1] <<< SH;
                    ny_reg[k] <= ny_reg[k-1] <<< SH;
                    nm_reg[k] <= nm_reg[k-1] << SH;
                end
                else
                begin
                    nx_reg[k] <= nx_reg[k-1];
                    ny_reg[k] <= ny_reg[k-1];
                    nm_reg[k] <= nm_reg[k-1];
                end
            end
        end
    end

    // fold the left half plane into the right one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (nx_reg[NRM_STEPS] < 0)
            begin
                if (ny_reg[NRM_STEPS] >= 0)
                begin
                    cx_reg[0] <= ny_reg[NRM_STEPS];
                    cy_reg[0] <= -nx_reg[NRM_STEPS];
                    cz_reg[0] <= ZW'(ANG_HALF_PI);
                end
                else
                begin
                    cx_reg[0] <= -ny_reg[NRM_STEPS];
                    cy_reg[0] <= nx_reg[NRM_STEPS];
                    cz_reg[0] <= -ZW'(ANG_HALF_PI);
                end
            end
            else
            begin
                cx_reg[0] <= nx_reg[NRM_STEPS];
                cy_reg[0] <= ny_reg[NRM_STEPS];
                cz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [CW-1:0] dx, dy;

        assign dx = cy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    cy_reg[i+1] <= cy_reg[i] - dy;
                    cz_reg[i+1] <= cz_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    cy_reg[i+1] <= cy_reg[i] + dy;
                    cz_reg[i+1] <= cz_reg[i] - ATAN_TAB[i];
                end
            end
        end
    end

    assign out_valid = v_reg[TOT-1];
    assign out_tag   = mt_reg[TOT-1].tag;
    assign out_z     = mt_reg[TOT-1].zero ? '0 : cz_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== sv/q2e_checker.sv =====
// Port-level checks of the converter and the bind that attaches them.
`default_nettype none

module q2e_checker import q2e_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    localparam logic signed [PITCH_W-1:0] P_MAX = PITCH_W'(OUT_HALF_PI);
    localparam logic signed [ROLL_W-1:0]  R_MAX = ROLL_W'(OUT_PI);

    logic signed [ROLL_W-1:0]  roll_w;
    logic signed [PITCH_W-1:0] pitch_w;

    assign roll_w  = m_axis_tdata[15:0];
    assign pitch_w = m_axis_tdata[30:16];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_lock_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[46:31] == '0)
        else $error("yaw not zero at gimbal lock");

    a_lock_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (pitch_w == P_MAX) || (pitch_w == -P_MAX))
        else $error("pitch not at a pole at gimbal lock");

    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pitch_w <= P_MAX) && (pitch_w >= -P_MAX))
        else $error("pitch out of range");

    a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (roll_w <= R_MAX) && (roll_w >= -R_MAX) && !m_axis_tdata[47])
        else $error("roll out of range or pad bit set");

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for quaternion_to_euler_angles: directed table and random requests.
`timescale 1ns / 100ps

module testbench;
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic               lock;
    } euler_t;

    typedef struct {
        logic [15:0] q0, q1, q2, q3;
        bit          has_fixed;   // expected angles typed in by hand
        euler_t      fixed;
    } quat_row_t;

    localparam int LATENCY   = 58;
    localparam int N_RANDOM  = 800;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    euler_t angle_queue[$];
    int     mismatch_count = 0;
    longint cycle_count = 0;
    bit     stall_mode = 0;

    quaternion_to_euler_angles DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // floor shift of a part product down to Q28
    function automatic longint prod_q28(input longint a, input longint b);
        return (a * b) >>> (2 * FRAC_BITS - 28);
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring CORDIC: angle of (x, y) in radians * 2^24
    function automatic longint vector_angle(input longint y, input longint x);
        longint unsigned mag;
        longint z, t, dx, dy;
        mag = (x < 0 ? -x : x) | (y < 0 ? -y : y);
        z = 0;
        if (mag == 0)
            return 0;
        while (mag < (64'd1 << 30))
        begin
            x = x * 2;
            y = y * 2;
            mag = mag << 1;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = ANG_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -ANG_HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(input longint z, input longint lim);
        longint r;
        r = (z + 1024) >>> 11;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t quat_to_euler(input logic [15:0] a0, input logic [15:0] a1,
                                             input logic [15:0] a2, input logic [15:0] a3);
        longint q0, q1, q2, q3, s, r, c, p00, p11, p22, p33;
        longint unsigned one_sq;
        euler_t e;
        q0 = longint'($signed(a0));
        q1 = longint'($signed(a1));
        q2 = longint'($signed(a2));
        q3 = longint'($signed(a3));
        s = 2 * (prod_q28(q0, q2) + prod_q28(q1, q3));
        if (s >= ONE_Q28 || s <= -ONE_Q28)
        begin
            // gimbal lock: roll from the scalar and first part only
            r = 2 * vector_angle(q1, q0);
            if (s > 0) r = -r;
            if (r > ANG_PI) r = r - 2 * longint'(ANG_PI);
            if (r < -ANG_PI) r = r + 2 * longint'(ANG_PI);
            e.roll  = 16'(round_angle(r, OUT_PI));
            e.pitch = (s > 0) ? 15'(OUT_HALF_PI) : -15'(OUT_HALF_PI);
            e.yaw   = '0;
            e.lock  = 1'b1;
        end
        else
        begin
            p00 = prod_q28(q0, q0);
            p11 = prod_q28(q1, q1);
            p22 = prod_q28(q2, q2);
            p33 = prod_q28(q3, q3);
            one_sq = 64'd1 << 56;
            c = int_sqrt(one_sq - longint'(s * s));
            e.pitch = 15'(round_angle(vector_angle(s, c), OUT_HALF_PI));
            e.roll  = 16'(round_angle(vector_angle(2 * (prod_q28(q0, q1) + prod_q28(q2, q3)),
                                                   p00 - p11 - p22 + p33), OUT_PI));
            e.yaw   = 16'(round_angle(vector_angle(2 * (prod_q28(q0, q3) + prod_q28(q1, q2)),
                                                   p00 + p11 - p22 - p33), OUT_PI));
            e.lock  = 1'b0;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // receiver: stall pattern changes every so often, with stall-free stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = ~stall_mode;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        euler_t want;
        cycle_count++;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angle_queue.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = angle_queue.pop_front();
                if ($signed(m_axis_tdata[15:0]) != want.roll)
                    report_mismatch("roll", $signed(m_axis_tdata[15:0]), want.roll);
                if ($signed(m_axis_tdata[30:16]) != want.pitch)
                    report_mismatch("pitch", $signed(m_axis_tdata[30:16]), want.pitch);
                if ($signed(m_axis_tdata[46:31]) != want.yaw)
                    report_mismatch("yaw", $signed(m_axis_tdata[46:31]), want.yaw);
                if (m_axis_tdata[47] !== 1'b0)
                    report_mismatch("pad bit", m_axis_tdata[47], 0);
                if (m_axis_tuser !== want.lock)
                    report_mismatch("gimbal_lock", m_axis_tuser, want.lock);
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // drive one request and hold it until accepted
    task automatic send_quat(input logic [15:0] a0, input logic [15:0] a1,
                             input logic [15:0] a2, input logic [15:0] a3,
                             input bit has_fixed, input euler_t fixed);
        euler_t e;
        e = quat_to_euler(a0, a1, a2, a3);
        if (has_fixed && e != fixed)
            report_mismatch("hand-typed row", e, fixed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a3, a2, a1, a0};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        angle_queue.push_back(has_fixed ? fixed : e);
    endtask

    task automatic idle_gap(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // a random unit-ish quaternion in Q2.14, near unit length
    task automatic random_unit(output logic [15:0] a0, output logic [15:0] a1,
                               output logic [15:0] a2, output logic [15:0] a3);
        real v[4], n;
        n = 0.0;
        for (int i = 0; i < 4; i++)
        begin
            v[i] = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
            n = n + v[i] * v[i];
        end
        if (n < 1e-6)
        begin
            v[0] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        a0 = 16'($rtoi(v[0] / n * 16384.0));
        a1 = 16'($rtoi(v[1] / n * 16384.0));
        a2 = 16'($rtoi(v[2] / n * 16384.0));
        a3 = 16'($rtoi(v[3] / n * 16384.0));
    endtask

    quat_row_t directed[$];

    function automatic quat_row_t row(input logic [15:0] a0, input logic [15:0] a1,
                                      input logic [15:0] a2, input logic [15:0] a3,
                                      input bit hf, input euler_t f);
        quat_row_t r;
        r.q0 = a0; r.q1 = a1; r.q2 = a2; r.q3 = a3;
        r.has_fixed = hf;
        r.fixed = f;
        return r;
    endfunction

    initial
    begin
        logic [15:0] a0, a1, a2, a3;
        int burst;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        // identity, zero vector, gimbal lock both ways, extremes, non-unit inputs
        directed.push_back(row(16'd16384, 0, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 0, lock: 0}));
        directed.push_back(row(0, 0, 0, 0, 1, '{yaw: 0, pitch: 0, roll: 0, lock: 0}));
        directed.push_back(row(16'd11585, 0, 16'd11585, 0, 0, '0));
        directed.push_back(row(16'd11585, 0, -16'sd11585, 0, 0, '0));
        directed.push_back(row(16'd11585, 16'd4000, 16'd11585, 16'd4000, 0, '0));
        directed.push_back(row(16'd16384, 0, 16'd16384, 0, 1,
                               '{yaw: 0, pitch: 15'(OUT_HALF_PI), roll: 0, lock: 1}));
        directed.push_back(row(16'd16384, 0, -16'sd16384, 0, 1,
                               '{yaw: 0, pitch: -15'(OUT_HALF_PI), roll: 0, lock: 1}));
        directed.push_back(row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, '0));
        directed.push_back(row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0));
        directed.push_back(row(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0, '0));
        directed.push_back(row(16'h7fff, 16'h8000, 0, 16'h7fff, 0, '0));
        directed.push_back(row(0, 16'd16384, 0, 0, 0, '0));
        directed.push_back(row(0, 0, 16'd16384, 0, 0, '0));
        directed.push_back(row(0, 0, 0, 16'd16384, 0, '0));
        directed.push_back(row(-16'sd16384, 0, 0, 0, 0, '0));
        directed.push_back(row(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, '0));
        directed.push_back(row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0, '0));
        directed.push_back(row(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0, '0));
        directed.push_back(row(16'd1, 0, 0, 0, 0, '0));
        directed.push_back(row(0, 16'd1, 0, 16'hffff, 0, '0));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_quat(directed[i].q0, directed[i].q1, directed[i].q2, directed[i].q3,
                      directed[i].has_fixed, directed[i].fixed);

        // hold the sender until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge clk);

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        a0 = $urandom; a1 = $urandom; a2 = $urandom; a3 = $urandom;
                    end
                    2:
                    begin
                        // push toward the gimbal lock boundary
                        a0 = 16'($urandom_range(11000, 12200));
                        a2 = $urandom_range(0, 1) ? a0 : -a0;
                        a1 = 16'($urandom_range(0, 300)) - 16'd150;
                        a3 = $urandom_range(0, 1) ? a1 : -a1;
                    end
                    default: random_unit(a0, a1, a2, a3);
                endcase
                send_quat(a0, a1, a2, a3, 0, '0);
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        while (angle_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
